FILE: rtl/core/fcsd_pkg.sv
// Package for the animation chunk decoder: word types, chunk codes and parser phases.
package fcsd_pkg;

   // Chunk kinds carried with the first body byte
   localparam logic [2:0] CHUNK_PALETTE = 3'd0;
   localparam logic [2:0] CHUNK_DELTA   = 3'd1;
   localparam logic [2:0] CHUNK_CLEAR   = 3'd2;
   localparam logic [2:0] CHUNK_RUN     = 3'd3;
   localparam logic [2:0] CHUNK_RAW     = 3'd4;

   localparam logic TARGET_FRAME   = 1'b0;
   localparam logic TARGET_PALETTE = 1'b1;

   localparam int COMPONENTS = 3;
   // Palette count byte of zero means 256 colors
   localparam logic [9:0] PAL_FULL_BYTES = 10'h300;
   localparam logic [8:0] SIZE_NEG_BASE  = 9'h100;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_PAL_HDR,
      PH_PAL_SKIP,
      PH_PAL_COUNT,
      PH_PAL_DATA,
      PH_LC_HDR,
      PH_LC_NPK,
      PH_LC_SKIP,
      PH_LC_SIZE,
      PH_LC_COPY,
      PH_LC_FILL,
      PH_BR_NPK,
      PH_BR_SIZE,
      PH_BR_COPY,
      PH_BR_FILL,
      PH_RAW
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [2:0] req_type;
      logic       chunk_first;
   } item_type;

   typedef struct packed {
      logic        hit;
      logic        target;
      logic [15:0] address;
      logic [7:0]  value;
      logic [15:0] count;
   } cmd_type;

endpackage

FILE: rtl/core/fcsd_in_reg.sv
// Input register stage: holds one body byte word until the parser takes it.
module fcsd_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  fcsd_pkg::item_type req_item,
   input  logic              advance,
   output logic              req_stall,
   output logic              item_valid,
   output fcsd_pkg::item_type item
);

   logic               valid_ff;
   fcsd_pkg::item_type item_ff;

   assign req_stall  = valid_ff && !advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

endmodule

FILE: rtl/core/fcsd_parser.sv
// Chunk parser: phase machine, counters and write command generation for one byte a cycle while go is high.
module fcsd_parser #(
   parameter int LINE_WIDTH      = 320,
   parameter int FRAME_LINES     = 200,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  fcsd_pkg::item_type item,
   output fcsd_pkg::cmd_type  cmd
);

   localparam int FRAME_BYTES = LINE_WIDTH * FRAME_LINES;
   localparam int PAL_SIZE    = PALETTE_ENTRIES * fcsd_pkg::COMPONENTS;
   localparam int LIMIT_MAX   = (FRAME_BYTES > PAL_SIZE) ? FRAME_BYTES : PAL_SIZE;
   // Positions saturate at all ones, well past either store end
   localparam int POS_W = $clog2(LIMIT_MAX + 1) + 1;
   localparam int INC_W = $clog2(LINE_WIDTH + 1) > 10 ? $clog2(LINE_WIDTH + 1) : 10;
   localparam int SUM_W = POS_W + INC_W;
   localparam int MUL_W = 16 + INC_W;
   localparam int EW    = (POS_W > 16) ? POS_W : 16;

   localparam logic [POS_W-1:0] POS_CAP     = '1;
   localparam logic [POS_W-1:0] FRAME_LIMIT = POS_W'(FRAME_BYTES);
   localparam logic [POS_W-1:0] PAL_LIMIT   = POS_W'(PAL_SIZE);
   localparam logic [15:0]      CLEAR_COUNT = 16'(FRAME_BYTES);
   localparam logic [15:0]      RUN_LINES   = 16'(FRAME_LINES);

   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [INC_W-1:0] inc);
      logic [SUM_W-1:0] s;
      s = SUM_W'(a) + SUM_W'(inc);
      return (s > SUM_W'(POS_CAP)) ? POS_CAP : s[POS_W-1:0];
   endfunction

   fcsd_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [7:0]       low_ff, low_in, cur_low;
   logic [15:0]      lines_ff, lines_in, cur_lines;
   logic [POS_W-1:0] base_ff, base_in, cur_base;
   logic [15:0]      pkts_ff, pkts_in, cur_pkts;
   logic [9:0]       bytes_ff, bytes_in, cur_bytes;
   logic [POS_W-1:0] pos_ff, pos_in, cur_pos;

   logic [7:0]       b;
   logic             is_clear;
   logic             pkt_done, line_done;
   logic [15:0]      pkts_dec, lines_dec, word;
   logic [MUL_W-1:0] prod;
   logic [POS_W-1:0] pos_next;
   fcsd_pkg::phase_type pkt_next, npk_next;

   logic             em_en, em_tgt;
   logic [9:0]       em_n;
   logic [POS_W-1:0] em_limit, remain;
   logic [EW-1:0]    n_ext, rem_ext, cnt_ext, addr_ext;

   assign b        = item.data_byte;
   assign is_clear = item.chunk_first && (item.req_type == fcsd_pkg::CHUNK_CLEAR);
   assign word     = {b, cur_low};
   assign prod     = MUL_W'(word) * MUL_W'(LINE_WIDTH);

   // A first byte restarts the parser from cleared state before it is parsed
   always_comb begin
      cur_phase = phase_ff;
      cur_low   = low_ff;
      cur_lines = lines_ff;
      cur_base  = base_ff;
      cur_pkts  = pkts_ff;
      cur_bytes = bytes_ff;
      cur_pos   = pos_ff;
      if (item.chunk_first) begin
         cur_low   = '0;
         cur_lines = '0;
         cur_base  = '0;
         cur_pkts  = '0;
         cur_bytes = '0;
         cur_pos   = '0;
         unique case (item.req_type)
            fcsd_pkg::CHUNK_PALETTE: cur_phase = fcsd_pkg::PH_PAL_HDR;
            fcsd_pkg::CHUNK_DELTA:   cur_phase = fcsd_pkg::PH_LC_HDR;
            fcsd_pkg::CHUNK_RUN: begin
               cur_phase = fcsd_pkg::PH_BR_NPK;
               cur_lines = RUN_LINES;
            end
            fcsd_pkg::CHUNK_RAW:     cur_phase = fcsd_pkg::PH_RAW;
            default:                 cur_phase = fcsd_pkg::PH_IDLE;
         endcase
      end
   end

   // Next state
   always_comb begin
      phase_in  = cur_phase;
      low_in    = cur_low;
      lines_in  = cur_lines;
      base_in   = cur_base;
      pkts_in   = cur_pkts;
      bytes_in  = cur_bytes;
      pos_in    = cur_pos;
      pkt_done  = 1'b0;
      line_done = 1'b0;
      pkt_next  = fcsd_pkg::PH_LC_SKIP;
      npk_next  = fcsd_pkg::PH_LC_NPK;
      pos_next  = sat_add(cur_pos, INC_W'(1));
      pkts_dec  = '0;
      lines_dec = '0;

      unique case (cur_phase)
         fcsd_pkg::PH_IDLE: begin
         end
         fcsd_pkg::PH_PAL_HDR: begin
            if (cur_bytes == '0) begin
               low_in   = b;
               bytes_in = 10'd1;
            end else begin
               pkts_in  = word;
               bytes_in = '0;
               pos_in   = '0;
               phase_in = (word == '0) ? fcsd_pkg::PH_IDLE : fcsd_pkg::PH_PAL_SKIP;
            end
         end
         fcsd_pkg::PH_PAL_SKIP: begin
            pos_in   = sat_add(cur_pos, INC_W'(b) * INC_W'(fcsd_pkg::COMPONENTS));
            phase_in = fcsd_pkg::PH_PAL_COUNT;
         end
         fcsd_pkg::PH_PAL_COUNT: begin
            bytes_in = (b == '0) ? fcsd_pkg::PAL_FULL_BYTES
                                 : 10'(b) * 10'(fcsd_pkg::COMPONENTS);
            phase_in = fcsd_pkg::PH_PAL_DATA;
         end
         fcsd_pkg::PH_PAL_DATA: begin
            pos_in   = pos_next;
            bytes_in = cur_bytes - 10'd1;
            if (bytes_in == '0) begin
               pkts_in  = cur_pkts - 16'd1;
               phase_in = (pkts_in == '0) ? fcsd_pkg::PH_IDLE : fcsd_pkg::PH_PAL_SKIP;
            end
         end
         fcsd_pkg::PH_LC_HDR: begin
            if (!cur_bytes[0]) begin
               low_in   = b;
               bytes_in = cur_bytes + 10'd1;
            end else if (cur_bytes == 10'd1) begin
               base_in  = (prod > MUL_W'(POS_CAP)) ? POS_CAP : prod[POS_W-1:0];
               bytes_in = 10'd2;
            end else begin
               lines_in = word;
               bytes_in = '0;
               phase_in = (word == '0) ? fcsd_pkg::PH_IDLE : fcsd_pkg::PH_LC_NPK;
            end
         end
         fcsd_pkg::PH_LC_NPK, fcsd_pkg::PH_BR_NPK: begin
            npk_next = cur_phase;
            pkts_in  = 16'(b);
            pos_in   = cur_base;
            if (b == '0) begin
               line_done = 1'b1;
            end else begin
               phase_in = (cur_phase == fcsd_pkg::PH_LC_NPK) ? fcsd_pkg::PH_LC_SKIP
                                                             : fcsd_pkg::PH_BR_SIZE;
            end
         end
         fcsd_pkg::PH_LC_SKIP: begin
            pos_in   = sat_add(cur_pos, INC_W'(b));
            phase_in = fcsd_pkg::PH_LC_SIZE;
         end
         fcsd_pkg::PH_LC_SIZE: begin
            if (b[7]) begin
               bytes_in = 10'(fcsd_pkg::SIZE_NEG_BASE - 9'(b));
               phase_in = fcsd_pkg::PH_LC_FILL;
            end else if (b == '0) begin
               pkt_done = 1'b1;
            end else begin
               bytes_in = 10'(b);
               phase_in = fcsd_pkg::PH_LC_COPY;
            end
         end
         fcsd_pkg::PH_LC_COPY, fcsd_pkg::PH_BR_COPY: begin
            if (cur_phase == fcsd_pkg::PH_BR_COPY) begin
               pkt_next = fcsd_pkg::PH_BR_SIZE;
               npk_next = fcsd_pkg::PH_BR_NPK;
            end
            pos_in   = pos_next;
            bytes_in = cur_bytes - 10'd1;
            pkt_done = (bytes_in == '0);
         end
         fcsd_pkg::PH_LC_FILL, fcsd_pkg::PH_BR_FILL: begin
            if (cur_phase == fcsd_pkg::PH_BR_FILL) begin
               pkt_next = fcsd_pkg::PH_BR_SIZE;
               npk_next = fcsd_pkg::PH_BR_NPK;
            end
            pos_in   = sat_add(cur_pos, INC_W'(cur_bytes));
            bytes_in = '0;
            pkt_done = 1'b1;
         end
         fcsd_pkg::PH_BR_SIZE: begin
            if (b[7]) begin
               bytes_in = 10'(fcsd_pkg::SIZE_NEG_BASE - 9'(b));
               phase_in = fcsd_pkg::PH_BR_COPY;
            end else begin
               bytes_in = 10'(b);
               phase_in = fcsd_pkg::PH_BR_FILL;
            end
         end
         fcsd_pkg::PH_RAW: begin
            pos_in = pos_next;
            if (pos_next >= FRAME_LIMIT) begin
               phase_in = fcsd_pkg::PH_IDLE;
            end
         end
         default: begin
         end
      endcase

      if (pkt_done) begin
         pkts_dec = (cur_pkts != '0) ? cur_pkts - 16'd1 : cur_pkts;
         pkts_in  = pkts_dec;
         if (pkts_dec == '0) begin
            line_done = 1'b1;
         end else begin
            phase_in = pkt_next;
         end
      end

      if (line_done) begin
         base_in   = sat_add(cur_base, INC_W'(LINE_WIDTH));
         lines_dec = (cur_lines != '0) ? cur_lines - 16'd1 : cur_lines;
         lines_in  = lines_dec;
         phase_in  = (lines_dec == '0) ? fcsd_pkg::PH_IDLE : npk_next;
      end
   end

   // Command output
   always_comb begin
      em_en    = 1'b0;
      em_tgt   = fcsd_pkg::TARGET_FRAME;
      em_n     = 10'd1;
      em_limit = FRAME_LIMIT;
      unique case (cur_phase)
         fcsd_pkg::PH_PAL_DATA: begin
            em_en    = 1'b1;
            em_tgt   = fcsd_pkg::TARGET_PALETTE;
            em_limit = PAL_LIMIT;
         end
         fcsd_pkg::PH_LC_COPY, fcsd_pkg::PH_BR_COPY, fcsd_pkg::PH_RAW: begin
            em_en = 1'b1;
         end
         fcsd_pkg::PH_LC_FILL, fcsd_pkg::PH_BR_FILL: begin
            em_en = 1'b1;
            em_n  = cur_bytes;
         end
         default: begin
         end
      endcase

      remain   = em_limit - cur_pos;
      n_ext    = EW'(em_n);
      rem_ext  = EW'(remain);
      cnt_ext  = (n_ext < rem_ext) ? n_ext : rem_ext;
      addr_ext = EW'(cur_pos);

      cmd.hit     = go && em_en && (cur_pos < em_limit) && (em_n != '0);
      cmd.target  = em_tgt;
      cmd.address = addr_ext[15:0];
      cmd.value   = b;
      cmd.count   = cnt_ext[15:0];
      if (is_clear) begin
         cmd.hit     = go;
         cmd.target  = fcsd_pkg::TARGET_FRAME;
         cmd.address = '0;
         cmd.value   = '0;
         cmd.count   = CLEAR_COUNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fcsd_pkg::PH_IDLE;
         low_ff   <= '0;
         lines_ff <= '0;
         base_ff  <= '0;
         pkts_ff  <= '0;
         bytes_ff <= '0;
         pos_ff   <= '0;
      end else if (go) begin
         phase_ff <= phase_in;
         low_ff   <= low_in;
         lines_ff <= lines_in;
         base_ff  <= base_in;
         pkts_ff  <= pkts_in;
         bytes_ff <= bytes_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

FILE: rtl/core/fcsd_out_reg.sv
// Result register: holds one write command word until the sink takes it.
module fcsd_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  fcsd_pkg::cmd_type cmd,
   input  logic              rsp_stall,
   output logic              advance,
   output logic              rsp_valid,
   output logic              rsp_target,
   output logic [15:0]       rsp_address,
   output logic [7:0]        rsp_value,
   output logic [15:0]       rsp_count
);

   logic              valid_ff;
   fcsd_pkg::cmd_type cmd_ff;

   // Free when empty or being drained this cycle
   assign advance     = !valid_ff || !rsp_stall;
   assign rsp_valid   = valid_ff;
   assign rsp_target  = cmd_ff.target;
   assign rsp_address = cmd_ff.address;
   assign rsp_value   = cmd_ff.value;
   assign rsp_count   = cmd_ff.count;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= cmd.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && cmd.hit) begin
         cmd_ff <= cmd;
      end
   end

endmodule

FILE: rtl/core/fli_chunk_stream_decoder.sv
// Top level of the animation chunk decoder: input stage, parser and result register.
//
// Takes one chunk body byte per cycle while req_stall is low and turns it into
// at most one frame or palette write command (target, address, value, count).
// A byte with req_chunk_first set restarts the parser with the kind given on
// req_type. Sustained rate is one word per cycle in both directions while
// rsp_stall is low; the byte is held in the input register and its command
// is then captured in the result register, which drives rsp_valid. The rate
// is set by the parser's phase machine, which updates its counters and
// positions for each byte as it is taken from the input register.
// Nothing needs clearing after reset.
module fli_chunk_stream_decoder #(
   parameter int LINE_WIDTH      = 320,
   parameter int FRAME_LINES     = 200,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [2:0]  req_type,
   input  logic        req_chunk_first,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_target,
   output logic [15:0] rsp_address,
   output logic [7:0]  rsp_value,
   output logic [15:0] rsp_count
);

   fcsd_pkg::item_type req_item, item;
   fcsd_pkg::cmd_type  cmd;
   logic               item_valid, advance;

   assign req_item.data_byte   = req_data_byte;
   assign req_item.req_type    = req_type;
   assign req_item.chunk_first = req_chunk_first;

   fcsd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .advance    (advance),
      .req_stall  (req_stall),
      .item_valid (item_valid),
      .item       (item)
   );

   fcsd_parser #(
      .LINE_WIDTH      (LINE_WIDTH),
      .FRAME_LINES     (FRAME_LINES),
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .go    (item_valid && advance),
      .item  (item),
      .cmd   (cmd)
   );

   fcsd_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rsp_stall   (rsp_stall),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_target  (rsp_target),
      .rsp_address (rsp_address),
      .rsp_value   (rsp_value),
      .rsp_count   (rsp_count)
   );

endmodule

FILE: test/fli_chunk_stream_decoder_test.sv
// Self-checking testbench for the animation chunk decoder: directed and random chunks.
`timescale 1ns / 1ps

module fli_chunk_stream_decoder_test;

   localparam int unsigned LINE_WIDTH      = 320;
   localparam int unsigned FRAME_LINES     = 200;
   localparam int unsigned PALETTE_ENTRIES = 256;
   localparam int unsigned FRAME_BYTES     = LINE_WIDTH * FRAME_LINES;
   localparam int unsigned PAL_SIZE        = PALETTE_ENTRIES * fcsd_pkg::COMPONENTS;
   localparam int unsigned POS_CAP         = 32'h4000_0000;

   // Kinds 5..7 start a chunk that the decoder drops
   localparam logic [2:0] CHUNK_IGNORED_FIRST = 3'd5;
   localparam logic [2:0] CHUNK_IGNORED_LAST  = 3'd7;

   localparam int RANDOM_END  = 1150;
   localparam int LONG_HOLD   = 300;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 20;

   typedef struct packed {
      logic        target;
      logic [15:0] address;
      logic [7:0]  value;
      logic [15:0] count;
   } write_cmd_type;

   class write_cmd_board;
      write_cmd_type pending_writes[$];
      int            mismatches;
      int            checked;

      fcsd_pkg::phase_type phase;
      logic [7:0]  low_hold;
      logic [15:0] lines_left;
      int unsigned line_base;
      logic [15:0] packets_left;
      int unsigned bytes_left;
      int unsigned write_pos;
      logic [7:0]  skip_hold;

      function new();
         mismatches = 0;
         checked = 0;
         restart_parser();
      endfunction

      function void restart_parser();
         phase = fcsd_pkg::PH_IDLE;
         low_hold = 8'h00;
         lines_left = 16'h0000;
         line_base = 0;
         packets_left = 16'h0000;
         bytes_left = 0;
         write_pos = 0;
         skip_hold = 8'h00;
      endfunction

      function int unsigned sat_add(int unsigned a, int unsigned b);
         if (a >= POS_CAP || b >= POS_CAP - a) return POS_CAP;
         return a + b;
      endfunction

      // Clip the run at the store end; a run starting past the end writes nothing
      function void queue_write(logic tgt, int unsigned addr, logic [7:0] val,
                                int unsigned n, int unsigned limit);
         write_cmd_type w;
         int unsigned   c;
         if (addr >= limit || n == 0) return;
         c = limit - addr;
         if (n < c) c = n;
         w.target = tgt;
         w.address = 16'(addr);
         w.value = val;
         w.count = 16'(c);
         pending_writes.push_back(w);
      endfunction

      function void line_done(fcsd_pkg::phase_type npk_phase);
         line_base = sat_add(line_base, LINE_WIDTH);
         if (lines_left > 0) lines_left--;
         phase = (lines_left == 0) ? fcsd_pkg::PH_IDLE : npk_phase;
      endfunction

      function void packet_done(fcsd_pkg::phase_type next_phase,
                                fcsd_pkg::phase_type npk_phase);
         if (packets_left > 0) packets_left--;
         if (packets_left == 0) line_done(npk_phase);
         else phase = next_phase;
      endfunction

      function void begin_line(logic [7:0] b, fcsd_pkg::phase_type npk_phase,
                               fcsd_pkg::phase_type pkt_phase);
         packets_left = 16'(b);
         write_pos = line_base;
         if (b == 0) line_done(npk_phase);
         else phase = pkt_phase;
      endfunction

      function void decode_byte(logic [7:0] b, logic [2:0] kind, logic first);
         logic [15:0] w;
         if (first) begin
            restart_parser();
            case (kind)
               fcsd_pkg::CHUNK_PALETTE: phase = fcsd_pkg::PH_PAL_HDR;
               fcsd_pkg::CHUNK_DELTA:   phase = fcsd_pkg::PH_LC_HDR;
               fcsd_pkg::CHUNK_CLEAR: begin
                  queue_write(fcsd_pkg::TARGET_FRAME, 0, 8'h00, FRAME_BYTES, FRAME_BYTES);
                  return;
               end
               fcsd_pkg::CHUNK_RUN: begin
                  phase = fcsd_pkg::PH_BR_NPK;
                  lines_left = 16'(FRAME_LINES);
               end
               fcsd_pkg::CHUNK_RAW:     phase = fcsd_pkg::PH_RAW;
               default:                 return;
            endcase
         end
         w = {b, low_hold};
         case (phase)
            fcsd_pkg::PH_PAL_HDR: begin
               if (bytes_left == 0) begin
                  low_hold = b;
                  bytes_left = 1;
               end else begin
                  packets_left = w;
                  bytes_left = 0;
                  write_pos = 0;
                  phase = (w == 0) ? fcsd_pkg::PH_IDLE : fcsd_pkg::PH_PAL_SKIP;
               end
            end
            fcsd_pkg::PH_PAL_SKIP: begin
               skip_hold = b;
               write_pos = sat_add(write_pos, 32'(b) * fcsd_pkg::COMPONENTS);
               phase = fcsd_pkg::PH_PAL_COUNT;
            end
            fcsd_pkg::PH_PAL_COUNT: begin
               bytes_left = (b == 0) ? 32'(fcsd_pkg::PAL_FULL_BYTES)
                                     : 32'(b) * fcsd_pkg::COMPONENTS;
               phase = fcsd_pkg::PH_PAL_DATA;
            end
            fcsd_pkg::PH_PAL_DATA: begin
               queue_write(fcsd_pkg::TARGET_PALETTE, write_pos, b, 1, PAL_SIZE);
               write_pos = sat_add(write_pos, 1);
               bytes_left--;
               if (bytes_left == 0) begin
                  packets_left--;
                  phase = (packets_left == 0) ? fcsd_pkg::PH_IDLE : fcsd_pkg::PH_PAL_SKIP;
               end
            end
            fcsd_pkg::PH_LC_HDR: begin
               // header byte index: start line word, then line count word
               if (bytes_left[0] == 1'b0) begin
                  low_hold = b;
                  bytes_left++;
               end else if (bytes_left == 1) begin
                  line_base = 32'(w) * LINE_WIDTH;
                  bytes_left = 2;
               end else begin
                  lines_left = w;
                  bytes_left = 0;
                  phase = (w == 0) ? fcsd_pkg::PH_IDLE : fcsd_pkg::PH_LC_NPK;
               end
            end
            fcsd_pkg::PH_LC_NPK: begin_line(b, fcsd_pkg::PH_LC_NPK, fcsd_pkg::PH_LC_SKIP);
            fcsd_pkg::PH_LC_SKIP: begin
               skip_hold = b;
               write_pos = sat_add(write_pos, 32'(b));
               phase = fcsd_pkg::PH_LC_SIZE;
            end
            fcsd_pkg::PH_LC_SIZE: begin
               if (b[7]) begin
                  bytes_left = 32'(fcsd_pkg::SIZE_NEG_BASE) - 32'(b);
                  phase = fcsd_pkg::PH_LC_FILL;
               end else if (b == 0) begin
                  packet_done(fcsd_pkg::PH_LC_SKIP, fcsd_pkg::PH_LC_NPK);
               end else begin
                  bytes_left = 32'(b);
                  phase = fcsd_pkg::PH_LC_COPY;
               end
            end
            fcsd_pkg::PH_LC_COPY, fcsd_pkg::PH_BR_COPY: begin
               queue_write(fcsd_pkg::TARGET_FRAME, write_pos, b, 1, FRAME_BYTES);
               write_pos = sat_add(write_pos, 1);
               bytes_left--;
               if (bytes_left == 0) begin
                  if (phase == fcsd_pkg::PH_LC_COPY)
                     packet_done(fcsd_pkg::PH_LC_SKIP, fcsd_pkg::PH_LC_NPK);
                  else
                     packet_done(fcsd_pkg::PH_BR_SIZE, fcsd_pkg::PH_BR_NPK);
               end
            end
            fcsd_pkg::PH_LC_FILL, fcsd_pkg::PH_BR_FILL: begin
               queue_write(fcsd_pkg::TARGET_FRAME, write_pos, b, bytes_left, FRAME_BYTES);
               write_pos = sat_add(write_pos, bytes_left);
               bytes_left = 0;
               if (phase == fcsd_pkg::PH_LC_FILL)
                  packet_done(fcsd_pkg::PH_LC_SKIP, fcsd_pkg::PH_LC_NPK);
               else
                  packet_done(fcsd_pkg::PH_BR_SIZE, fcsd_pkg::PH_BR_NPK);
            end
            fcsd_pkg::PH_BR_NPK: begin_line(b, fcsd_pkg::PH_BR_NPK, fcsd_pkg::PH_BR_SIZE);
            fcsd_pkg::PH_BR_SIZE: begin
               // byte run has the sign sense reversed: negative copies
               if (b[7]) begin
                  bytes_left = 32'(fcsd_pkg::SIZE_NEG_BASE) - 32'(b);
                  phase = fcsd_pkg::PH_BR_COPY;
               end else begin
                  bytes_left = 32'(b);
                  phase = fcsd_pkg::PH_BR_FILL;
               end
            end
            fcsd_pkg::PH_RAW: begin
               queue_write(fcsd_pkg::TARGET_FRAME, write_pos, b, 1, FRAME_BYTES);
               write_pos = sat_add(write_pos, 1);
               if (write_pos >= FRAME_BYTES) phase = fcsd_pkg::PH_IDLE;
            end
            default: ;
         endcase
      endfunction

      function void note_input(logic [7:0] b, logic [2:0] kind, logic first);
         decode_byte(b, kind, first);
      endfunction

      function void check_result(write_cmd_type got);
         write_cmd_type want;
         if (pending_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected write: target %0d addr %0d value 0x%02h count %0d",
                        got.target, got.address, got.value, got.count);
            return;
         end
         want = pending_writes.pop_front();
         checked++;
         if (got.target !== want.target || got.address !== want.address ||
             got.value !== want.value || got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("write mismatch: expected target %0d addr %0d value 0x%02h count %0d, %s",
                        want.target, want.address, want.value, want.count,
                        $sformatf("got target %0d addr %0d value 0x%02h count %0d",
                                  got.target, got.address, got.value, got.count));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic [2:0]  req_type = fcsd_pkg::CHUNK_PALETTE;
   logic        req_chunk_first = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_target;
   logic [15:0] rsp_address;
   logic [7:0]  rsp_value;
   logic [15:0] rsp_count;

   write_cmd_board board = new();
   logic [7:0]     body[$];
   int             items_sent = 0;
   int             burst_left = 0;
   int             idle_cycles = 0;
   bit             hold_request = 0;

   fli_chunk_stream_decoder #(
      .LINE_WIDTH(LINE_WIDTH),
      .FRAME_LINES(FRAME_LINES),
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_type(req_type),
      .req_chunk_first(req_chunk_first),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_target(rsp_target),
      .rsp_address(rsp_address),
      .rsp_value(rsp_value),
      .rsp_count(rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result('{rsp_target, rsp_address, rsp_value, rsp_count});
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver: random stall patterns that change from span to span, plus one long hold-off
   initial begin
      int mode;
      int span;
      int k;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 0;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(30, 200);
            for (k = 0; k < span; k++) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= k[0];
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic send_word(logic [7:0] b, logic [2:0] kind, logic first);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_type <= kind;
      req_chunk_first <= first;
      do @(posedge clock); while (req_stall);
      board.note_input(b, kind, first);
      items_sent++;
      burst_left--;
   endtask

   // Only the first word carries the kind; later words get random junk there
   task automatic send_chunk(logic [2:0] kind);
      for (int i = 0; i < body.size(); i++)
         send_word(body[i], (i == 0) ? kind : 3'($urandom_range(0, 7)), i == 0);
   endtask

   function automatic void put_word(int unsigned w);
      body.push_back(w[7:0]);
      body.push_back(w[15:8]);
   endfunction

   function automatic void build_palette(bit full_packet);
      int npk;
      int cnt;
      npk = full_packet ? 1 : $urandom_range(0, 3);
      put_word(npk);
      for (int p = 0; p < npk; p++) begin
         if (full_packet) body.push_back(8'h00);
         else if ($urandom_range(0, 4) == 0) body.push_back(8'($urandom_range(200, 255)));
         else body.push_back(8'($urandom_range(0, 20)));
         cnt = full_packet ? 0 : $urandom_range(1, 4);
         body.push_back(8'(cnt));
         repeat ((cnt == 0) ? fcsd_pkg::PAL_FULL_BYTES : cnt * fcsd_pkg::COMPONENTS)
            body.push_back(8'($urandom));
      end
   endfunction

   function automatic void build_delta();
      int lines;
      int npk;
      int n;
      case ($urandom_range(0, 9))
         0:       put_word($urandom_range(0, 65535));
         1, 2:    put_word($urandom_range(190, 210));
         default: put_word($urandom_range(0, FRAME_LINES - 1));
      endcase
      lines = $urandom_range(0, 3);
      put_word(lines);
      repeat (lines) begin
         npk = $urandom_range(0, 3);
         body.push_back(8'(npk));
         repeat (npk) begin
            body.push_back(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 3))
               0: body.push_back(8'h00);
               1: begin
                  n = $urandom_range(1, 4);
                  body.push_back(8'(n));
                  repeat (n) body.push_back(8'($urandom));
               end
               2: begin
                  body.push_back(8'(256 - $urandom_range(1, 128)));
                  body.push_back(8'($urandom));
               end
               default: begin
                  body.push_back($urandom_range(0, 1) ? 8'h80 : 8'hFF);
                  body.push_back(8'($urandom));
               end
            endcase
         end
      end
   endfunction

   function automatic void build_run(bit full_frame);
      int lines;
      int npk;
      int n;
      lines = full_frame ? FRAME_LINES : $urandom_range(1, 12);
      for (int ln = 0; ln < lines; ln++) begin
         if (full_frame && ln == FRAME_LINES - 1) begin
            // three maximal fills on the last line run past the frame end
            body.push_back(8'd3);
            repeat (3) begin
               body.push_back(8'd127);
               body.push_back(8'($urandom));
            end
            continue;
         end
         if (full_frame) npk = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
         else npk = $urandom_range(0, 3);
         body.push_back(8'(npk));
         repeat (npk) begin
            if ($urandom_range(0, 1)) begin
               n = ($urandom_range(0, 15) == 0) ? 128 : $urandom_range(1, 4);
               body.push_back(8'(256 - n));
               repeat (n) body.push_back(8'($urandom));
            end else begin
               body.push_back(8'($urandom_range(0, 127)));
               body.push_back(8'($urandom));
            end
         end
      end
   endfunction

   initial begin
      logic [2:0] kind;
      bit         may_cut;
      bit         full_palette_done;
      bit         full_run_done;
      int         leftover;

      full_palette_done = 0;
      full_run_done = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: stray byte, clear, dropped kind, clipped palette, delta, raw
      send_word(8'hAA, fcsd_pkg::CHUNK_RAW, 1'b0);
      send_word(8'hFF, fcsd_pkg::CHUNK_CLEAR, 1'b1);
      send_word(8'h00, CHUNK_IGNORED_LAST, 1'b1);
      send_word(8'h55, CHUNK_IGNORED_FIRST, 1'b0);
      body = '{8'h01, 8'h00, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78};
      send_chunk(fcsd_pkg::CHUNK_PALETTE);
      // last line: 128-pixel fill, then a skip that lands past the frame end
      body = '{8'hC7, 8'h00, 8'h01, 8'h00, 8'h02, 8'h3C, 8'h80, 8'h5A,
               8'hFF, 8'h01, 8'hA5};
      send_chunk(fcsd_pkg::CHUNK_DELTA);
      send_word(8'h33, fcsd_pkg::CHUNK_DELTA, 1'b0);
      body = '{8'h00, 8'hFF};
      send_chunk(fcsd_pkg::CHUNK_RAW);

      hold_request = 1;
      while (items_sent < RANDOM_END) begin
         body.delete();
         may_cut = 1;
         kind = fcsd_pkg::CHUNK_PALETTE;
         case ($urandom_range(0, 9))
            0, 1: begin
               may_cut = full_palette_done;
               build_palette(!full_palette_done);
               full_palette_done = 1;
            end
            2, 3, 4: begin
               kind = fcsd_pkg::CHUNK_DELTA;
               build_delta();
            end
            5: begin
               kind = fcsd_pkg::CHUNK_CLEAR;
               body.push_back(8'($urandom));
            end
            6: begin
               kind = fcsd_pkg::CHUNK_RUN;
               may_cut = full_run_done;
               build_run(!full_run_done);
               full_run_done = 1;
            end
            7: begin
               kind = fcsd_pkg::CHUNK_RAW;
               repeat ($urandom_range(1, 16)) body.push_back(8'($urandom));
            end
            8: begin
               kind = 3'($urandom_range(CHUNK_IGNORED_FIRST, CHUNK_IGNORED_LAST));
               repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
            end
            default: begin
               repeat ($urandom_range(1, 4))
                  send_word(8'($urandom), 3'($urandom_range(0, 7)),
                            $urandom_range(0, 3) == 0);
            end
         endcase
         if (may_cut && body.size() > 2 && $urandom_range(0, 7) == 0)
            body = body[0:$urandom_range(0, body.size() - 2)];
         if (body.size() != 0) send_chunk(kind);
         repeat ($urandom_range(0, 2))
            send_word(8'($urandom), 3'($urandom_range(0, 7)), 1'b0);
      end
      req_valid <= 1'b0;

      while (board.pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      leftover = board.pending_writes.size();
      if (leftover != 0) $display("%0d expected writes never came out", leftover);
      if (board.mismatches > 10)
         $display("%0d further mismatches not shown", board.mismatches - 10);
      $display("Fed %0d chunk bytes and checked %0d write commands across palette, delta,",
               items_sent, board.checked);
      $display("byte run, clear, raw and dropped chunks, with clipping and output back-pressure.");
      if (board.mismatches == 0 && leftover == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
